// ----- hw/rtl/pmr_pkg.sv -----
// Package for the H-bridge PWM ramp block: item kinds, register indexes,
// the reversal step period and the sequencer state type.
// No dependencies; used by pwm_motor_ramp_with_reversal.
package pmr_pkg;

    // Item kinds carried in s_tuser.
    localparam logic [1:0] KIND_SET_TARGET = 2'd0;
    localparam logic [1:0] KIND_TICK       = 2'd1;
    localparam logic [1:0] KIND_REVERSE    = 2'd2;
    localparam logic [1:0] KIND_NOP        = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_MAX_SPEED = 1'b0;
    localparam logic CFG_MAX_JUMP  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0] MAX_SPEED_RESET = 8'd255;
    localparam logic [7:0] MAX_JUMP_RESET  = 8'd50;

    // Step period forced during a reversal and for large jumps.
    localparam logic [7:0] REVERSAL_STEP = 8'd20;

    // Width of the timestamp and the serial divider.
    localparam int TIME_W = 32;
    localparam int CNT_W  = $clog2(TIME_W);

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/pwm_motor_ramp_with_reversal.sv -----
// H-bridge PWM duty ramp with soft start and direction reversal.
// Holds the ramp state, a bit-serial elapsed-time divider and the output register.
// Depends on pmr_pkg.
//
//  Channel   Direction  Signals                          Contents
//  ------------------------------------------------------------------------------
//  s_        in         s_tvalid s_tready s_tdata s_tuser  one command item
//  m_        out        m_tvalid m_tready m_tdata          one result per item
//  cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// A tick with the duty off its goal and a nonzero step period goes through accept, the
// one-bit-per-cycle restoring divider of elapsed time by the step period, then commit.
// Every other item goes through accept, then commit.
// A result waits in the output register while the next item is accepted; the commit
// cycle holds only if that register is still full. Reset sets every control and ramp
// state register at once, with no clearing pass. cfg_ready is always high.
module pwm_motor_ramp_with_reversal
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: target[7:0], step_time[15:8], now[47:16]
    input  logic [47:0]                   s_tdata,
    // s_tuser: kind[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: left_duty[7:0], right_duty[15:8], pins_written[16], at_target[17],
    // reversing[18], zero padding[23:19]
    output logic [23:0]                   m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [7:0]                    cfg_data
);
    import pmr_pkg::*;

    // Architectural state.
    state_t              state_reg, state_next;
    logic [7:0]          max_speed_reg;
    logic [7:0]          max_jump_reg;
    logic [7:0]          duty_reg, duty_next;
    logic [7:0]          goal_reg, goal_next;
    logic [7:0]          period_reg, period_next;
    logic [TIME_W-1:0]   last_reg, last_next;
    logic [7:0]          saved_reg, saved_next;
    logic                pending_reg, pending_next;
    logic                stopped_reg, stopped_next;
    logic                side_reg, side_next;
    logic                m_tvalid_reg;

    // Latched item, divider and output payload.
    logic [1:0]          kind_reg;
    logic [7:0]          target_reg;
    logic [7:0]          step_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   quot_reg;
    logic [7:0]          rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [23:0]         m_tdata_reg;

    // Sequencer controls.
    logic                accept;
    logic                out_free;
    logic                commit;
    logic                div_run;
    logic                need_div;
    logic                wrote;

    // Divider step.
    logic [8:0]          rem_shift;
    logic                rem_ge;
    logic [8:0]          rem_sub;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // A tick needs the divider only when it ramps with a nonzero period.
    assign need_div = (s_tuser == KIND_TICK) && (duty_reg != goal_reg)
                      && (period_reg != 8'd0);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_div ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(TIME_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready = 1'b0;
        div_run  = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_DIV:
            begin
                div_run = 1'b1;
            end
            ST_DONE:
            begin
                commit = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign rem_shift = {rem_reg, quot_reg[TIME_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, period_reg};
    assign rem_sub   = rem_shift - {1'b0, period_reg};

    // Item update, applied in the commit cycle.
    always_comb
    begin
        logic [7:0] diff;
        logic [7:0] st_eff;
        logic [7:0] tgt_eff;
        logic [7:0] set_tgt;
        logic [7:0] set_st;
        logic       set_en;
        logic [7:0] ramp;
        logic [8:0] sum;
        logic       big;
        logic       change;

        duty_next    = duty_reg;
        goal_next    = goal_reg;
        period_next  = period_reg;
        last_next    = last_reg;
        saved_next   = saved_reg;
        pending_next = pending_reg;
        stopped_next = stopped_reg;
        side_next    = side_reg;
        wrote        = 1'b0;
        set_en       = 1'b0;
        set_tgt      = target_reg;
        set_st       = step_reg;
        ramp         = duty_reg;
        change       = 1'b0;
        big          = |quot_reg[TIME_W-1:8];
        sum          = {1'b0, duty_reg} + {1'b0, quot_reg[7:0]};

        case (kind_reg)
            KIND_SET_TARGET:
            begin
                set_en = !pending_reg;
            end
            KIND_TICK:
            begin
                if (duty_reg != goal_reg)
                begin
                    // A zero period jumps to the goal; no whole step leaves all untouched.
                    if (period_reg == 8'd0)
                    begin
                        ramp   = goal_reg;
                        change = 1'b1;
                    end
                    else if (quot_reg != '0)
                    begin
                        change = 1'b1;
                        if (duty_reg < goal_reg)
                        begin
                            if (big || sum >= {1'b0, goal_reg}
                                || sum > {1'b0, max_speed_reg})
                            begin
                                ramp = goal_reg;
                            end
                            else
                            begin
                                ramp = sum[7:0];
                            end
                        end
                        else
                        begin
                            if (big || quot_reg[7:0] >= (duty_reg - goal_reg))
                            begin
                                ramp = goal_reg;
                            end
                            else
                            begin
                                ramp = duty_reg - quot_reg[7:0];
                            end
                        end
                    end
                    if (change)
                    begin
                        last_next = now_reg;
                        if (ramp != duty_reg)
                        begin
                            duty_next    = ramp;
                            stopped_next = (ramp == 8'd0);
                            wrote        = 1'b1;
                        end
                    end
                end
                else if (pending_reg && stopped_reg)
                begin
                    // Stopped at zero: swap sides and ramp back to the saved duty.
                    side_next    = !side_reg;
                    pending_next = 1'b0;
                    set_en       = 1'b1;
                    set_tgt      = saved_reg;
                    set_st       = REVERSAL_STEP;
                end
            end
            KIND_REVERSE:
            begin
                saved_next   = duty_reg;
                goal_next    = 8'd0;
                period_next  = REVERSAL_STEP;
                pending_next = 1'b1;
                last_next    = now_reg;
            end
            default:
            begin
                duty_next = duty_reg;
            end
        endcase

        // Target update with the jump limit and the speed clamp.
        diff    = (duty_reg > set_tgt) ? (duty_reg - set_tgt) : (set_tgt - duty_reg);
        st_eff  = (set_st < REVERSAL_STEP && diff > max_jump_reg) ? REVERSAL_STEP : set_st;
        tgt_eff = (set_tgt > max_speed_reg) ? max_speed_reg : set_tgt;
        if (set_en)
        begin
            goal_next   = tgt_eff;
            period_next = st_eff;
            last_next   = now_reg;
        end
    end

    // Control and ramp state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_speed_reg <= MAX_SPEED_RESET;
            max_jump_reg  <= MAX_JUMP_RESET;
            duty_reg      <= 8'd0;
            goal_reg      <= 8'd0;
            period_reg    <= 8'd0;
            last_reg      <= '0;
            saved_reg     <= 8'd0;
            pending_reg   <= 1'b0;
            stopped_reg   <= 1'b1;
            side_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MAX_SPEED)
                begin
                    max_speed_reg <= cfg_data;
                end
                else
                begin
                    max_jump_reg <= cfg_data;
                end
            end
            if (commit)
            begin
                duty_reg    <= duty_next;
                goal_reg    <= goal_next;
                period_reg  <= period_next;
                last_reg    <= last_next;
                saved_reg   <= saved_next;
                pending_reg <= pending_next;
                stopped_reg <= stopped_next;
                side_reg    <= side_next;
            end
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item latch, serial divider and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= s_tuser;
            target_reg <= s_tdata[7:0];
            step_reg   <= s_tdata[15:8];
            now_reg    <= s_tdata[47:16];
            quot_reg   <= s_tdata[47:16] - last_reg;
            rem_reg    <= 8'd0;
            cnt_reg    <= '0;
        end
        else if (div_run)
        begin
            quot_reg <= {quot_reg[TIME_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? rem_sub[7:0] : rem_shift[7:0];
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
        if (commit)
        begin
            m_tdata_reg <= {5'd0, pending_next, (duty_next == goal_next), wrote,
                            (side_next ? duty_next : 8'd0),
                            (side_next ? 8'd0 : duty_next)};
        end
    end

    // The divider only runs with a nonzero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> period_reg != 8'd0)
        else $error("divider running with a zero step period");

    // After the last divide step the remainder is below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && $past(state_reg) == ST_DIV) |-> rem_reg < period_reg)
        else $error("divider remainder out of range");

    // A commit never overwrites a result that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before transaction");

    // Only one bridge side carries a nonzero duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[7:0] == 8'd0 || m_tdata_reg[15:8] == 8'd0))
        else $error("both bridge sides driven");

    // The divider takes no new item while it works.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |=> !$past(accept))
        else $error("item accepted during division");

endmodule

// ----- bench/tb_pwm_motor_ramp_with_reversal.sv -----
// Self-checking testbench for pwm_motor_ramp_with_reversal: directed and random
// command streams under several register settings and handshake idling patterns.
// Depends on pmr_pkg and the pwm_motor_ramp_with_reversal RTL.
module tb_pwm_motor_ramp_with_reversal;
    timeunit 1ns;
    timeprecision 1ps;

    import pmr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;

    // One command as it travels on the input stream.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  target;
        logic [7:0]  step_time;
        logic [31:0] now;
    } motor_cmd_t;

    // One bridge drive report as it travels on the output stream.
    typedef struct packed {
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        logic       pins_written;
        logic       at_target;
        logic       reversing;
    } drive_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = KIND_NOP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_MAX_SPEED;
    logic [7:0]  cfg_data = '0;

    pwm_motor_ramp_with_reversal dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Ramp state of the motor as the bench expects it.
    logic [7:0]  ramp_duty = 8'd0;
    logic [7:0]  ramp_goal = 8'd0;
    logic [7:0]  ramp_period = 8'd0;
    logic [31:0] ramp_stamp = 32'd0;
    logic [7:0]  duty_saved = 8'd0;
    logic        flip_pending = 1'b0;
    logic        motor_stopped = 1'b1;
    logic        side_b = 1'b0;
    logic [7:0]  lim_speed = MAX_SPEED_RESET;
    logic [7:0]  lim_jump = MAX_JUMP_RESET;

    motor_cmd_t   pending_cmds[$];
    drive_state_t expected_results[$];
    motor_cmd_t   on_bus;
    drive_state_t got;
    drive_state_t want;
    logic [31:0]  gen_clock = 32'd0;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int          cmds_queued = 0;
    int          results_seen = 0;
    int          error_count = 0;
    int          duty_changes = 0;
    int          side_swaps = 0;
    int          settings_used = 1;
    int          cycle_count = 0;

    // Clock and the single reset pulse.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stores a new goal unless a reversal owns the ramp.
    function automatic void load_goal(input logic [7:0] tgt, input logic [7:0] st,
                                      input logic [31:0] stamp);
        logic [7:0] gap;
        if (flip_pending)
            return;
        if (st < REVERSAL_STEP)
        begin
            gap = (ramp_duty > tgt) ? ramp_duty - tgt : tgt - ramp_duty;
            if (gap > lim_jump)
                st = REVERSAL_STEP;
        end
        ramp_goal = (tgt > lim_speed) ? lim_speed : tgt;
        ramp_period = st;
        ramp_stamp = stamp;
    endfunction

    // Applies one command to the ramp state and returns the drive it reports.
    function automatic drive_state_t step_ramp(input motor_cmd_t c);
        logic [31:0]  elapsed;
        logic [31:0]  steps;
        logic [32:0]  sum;
        logic [7:0]   next_duty;
        logic         wrote;
        drive_state_t r;
        wrote = 1'b0;
        case (c.kind)
            KIND_SET_TARGET:
                load_goal(c.target, c.step_time, c.now);
            KIND_TICK:
            begin
                if (ramp_duty != ramp_goal)
                begin
                    elapsed = c.now - ramp_stamp;
                    // A nonzero period with too little elapsed time leaves even the stamp alone.
                    if (ramp_period == 8'd0 || elapsed >= {24'd0, ramp_period})
                    begin
                        if (ramp_period == 8'd0)
                            next_duty = ramp_goal;
                        else
                        begin
                            steps = elapsed / {24'd0, ramp_period};
                            if (ramp_duty < ramp_goal)
                            begin
                                sum = {1'b0, steps} + {25'd0, ramp_duty};
                                if (sum >= {25'd0, ramp_goal} || sum > {25'd0, lim_speed})
                                    next_duty = ramp_goal;
                                else
                                    next_duty = sum[7:0];
                            end
                            else if (steps >= {24'd0, ramp_duty - ramp_goal})
                                next_duty = ramp_goal;
                            else
                                next_duty = ramp_duty - steps[7:0];
                        end
                        if (next_duty != ramp_duty)
                        begin
                            ramp_duty = next_duty;
                            motor_stopped = (ramp_duty == 8'd0);
                            wrote = 1'b1;
                        end
                        ramp_stamp = c.now;
                    end
                end
                else if (flip_pending && motor_stopped)
                begin
                    // Motor at rest: swap the bridge side and ramp back up.
                    side_b = ~side_b;
                    flip_pending = 1'b0;
                    side_swaps++;
                    load_goal(duty_saved, REVERSAL_STEP, c.now);
                end
            end
            KIND_REVERSE:
            begin
                duty_saved = ramp_duty;
                ramp_goal = 8'd0;
                ramp_period = REVERSAL_STEP;
                flip_pending = 1'b1;
                ramp_stamp = c.now;
            end
            default:
                ; // No-operation: the state stays as it is.
        endcase
        if (wrote)
            duty_changes++;
        r.left_duty = side_b ? 8'd0 : ramp_duty;
        r.right_duty = side_b ? ramp_duty : 8'd0;
        r.pins_written = wrote;
        r.at_target = (ramp_duty == ramp_goal);
        r.reversing = flip_pending;
        return r;
    endfunction

    function automatic void queue_cmd(input logic [1:0] kind, input logic [7:0] target,
                                      input logic [7:0] step_time, input logic [31:0] now);
        motor_cmd_t c;
        c.kind = kind;
        c.target = target;
        c.step_time = step_time;
        c.now = now;
        pending_cmds.push_back(c);
        cmds_queued++;
    endfunction

    // Mostly well-formed traffic on a moving timeline, with some noise commands.
    function automatic void queue_random_cmd();
        int unsigned pick;
        int unsigned roll;
        motor_cmd_t  c;
        pick = $urandom_range(99);
        roll = $urandom_range(99);
        if (roll >= 95)
            gen_clock = $urandom;
        else if (roll >= 80)
            gen_clock = gen_clock + $urandom_range(30000, 600);
        else if (roll >= 10)
            gen_clock = gen_clock + $urandom_range(600, 1);
        c.target = 8'($urandom_range(255));
        c.step_time = 8'($urandom_range(255));
        c.now = gen_clock;
        if (pick < 18)
        begin
            c.kind = KIND_SET_TARGET;
            roll = $urandom_range(9);
            if (roll < 3)
                c.step_time = 8'($urandom_range(19, 1));
            else if (roll == 3)
                c.step_time = 8'd0;
        end
        else if (pick < 75)
            c.kind = KIND_TICK;
        else if (pick < 85)
            c.kind = KIND_REVERSE;
        else if (pick < 92)
            c.kind = KIND_NOP;
        else
        begin
            c.kind = 2'($urandom_range(3));
            c.now = $urandom;
        end
        queue_cmd(c.kind, c.target, c.step_time, c.now);
    endfunction

    // Both registers are written back to back; valid drops once after the pair.
    task automatic write_settings(input logic [7:0] speed, input logic [7:0] jump);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAX_SPEED;
        cfg_data <= speed;
        do @(posedge clk); while (!cfg_ready);
        lim_speed = speed;
        cfg_index <= CFG_MAX_JUMP;
        cfg_data <= jump;
        do @(posedge clk); while (!cfg_ready);
        lim_jump = jump;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
        error_count++;
    endtask

    // Command driver: predicts each accepted transaction, then offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= KIND_NOP;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(step_ramp(on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {on_bus.now, on_bus.step_time, on_bus.target};
                    s_tuser <= on_bus.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each accepted transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.left_duty = m_tdata[7:0];
                got.right_duty = m_tdata[15:8];
                got.pins_written = m_tdata[16];
                got.at_target = m_tdata[17];
                got.reversing = m_tdata[18];
                if (expected_results.size() == 0)
                    report_mismatch("result with no command outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (got.left_duty !== want.left_duty)
                        report_mismatch($sformatf("left_duty %0d, expected %0d",
                                                  got.left_duty, want.left_duty));
                    if (got.right_duty !== want.right_duty)
                        report_mismatch($sformatf("right_duty %0d, expected %0d",
                                                  got.right_duty, want.right_duty));
                    if (got.pins_written !== want.pins_written)
                        report_mismatch($sformatf("pins_written %b, expected %b",
                                                  got.pins_written, want.pins_written));
                    if (got.at_target !== want.at_target)
                        report_mismatch($sformatf("at_target %b, expected %b",
                                                  got.at_target, want.at_target));
                    if (got.reversing !== want.reversing)
                        report_mismatch($sformatf("reversing %b, expected %b",
                                                  got.reversing, want.reversing));
                end
                results_seen++;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d of %0d results seen.",
                     cycle_count, results_seen, cmds_queued);
            $display("** pwm_motor_ramp_with_reversal: FAILED **");
            $finish;
        end
    end

    // Stimulus phases: each pairs a register setting with an idling pattern.
    initial
    begin
        int unsigned phase_speed[5];
        int unsigned phase_jump[5];
        int unsigned phase_send_idle[5];
        int unsigned phase_stall[5];
        int          phase_items[5];
        phase_speed = '{255, 255, 120, 0, 200};
        phase_jump = '{50, 0, 255, 10, 50};
        phase_send_idle = '{0, 56, 0, 22, 0};
        phase_stall = '{0, 0, 56, 22, 0};
        phase_items = '{400, 420, 420, 200, 420};

        @(posedge rst_n);
        for (int p = 0; p < 5; p++)
        begin
            // The first phase runs on the register reset values.
            if (p > 0)
                write_settings(8'(phase_speed[p]), 8'(phase_jump[p]));
            @(negedge clk);
            send_idle_pct = phase_send_idle[p];
            stall_pct = phase_stall[p];
            if (p == 0)
            begin
                // Idle block: tick at rest, then a no-operation with every field at its top.
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd0);
                queue_cmd(KIND_NOP, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
                // Zero step period jumps straight to the goal.
                queue_cmd(KIND_SET_TARGET, 8'd40, 8'd0, 32'd10);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd10);
                // Large jump with a short step forces the reversal step period.
                queue_cmd(KIND_SET_TARGET, 8'd255, 8'd5, 32'd100);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd119);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd160);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'hFFFF_FFFF);
                // Falling ramp across the timestamp wrap, then a drop that would go below zero.
                queue_cmd(KIND_SET_TARGET, 8'd0, 8'd255, 32'hFFFF_FFF0);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'h0000_0100);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'h0010_0000);
                queue_cmd(KIND_SET_TARGET, 8'd200, 8'd1, 32'd0);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd400);
                // Reversal: set-target ignored, restart mid-ramp, stop, swap, ramp back.
                queue_cmd(KIND_REVERSE, 8'd0, 8'd0, 32'd400);
                queue_cmd(KIND_SET_TARGET, 8'd100, 8'd3, 32'd410);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd420);
                queue_cmd(KIND_REVERSE, 8'd0, 8'd0, 32'd420);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd1000);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd1000);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd1100);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd5000);
                // Second reversal brings the drive back to the first side.
                queue_cmd(KIND_REVERSE, 8'd0, 8'd0, 32'd5000);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd6000);
                queue_cmd(KIND_TICK, 8'd0, 8'd0, 32'd6000);
                queue_cmd(KIND_NOP, 8'd0, 8'd0, 32'd0);
                gen_clock = 32'd6000;
            end
            for (int i = 0; i < phase_items[p]; i++)
                queue_random_cmd();
            wait (results_seen >= cmds_queued);
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Sent %0d commands and checked %0d results under %0d register settings.",
                 cmds_queued, results_seen, settings_used);
        $display("Predicted %0d duty changes and %0d completed direction swaps.",
                 duty_changes, side_swaps);
        if (error_count == 0)
            $display("** pwm_motor_ramp_with_reversal: PASSED **");
        else
            $display("** pwm_motor_ramp_with_reversal: FAILED **");
        $finish;
    end

endmodule
